@@ rtl/bds_pkg.sv @@
package bds_pkg;

  // Fixed field widths
  localparam int CLK_W  = 28;
  localparam int BAUD_W = 24;

  // Numerator of the shared divide is twice the reference clock
  localparam int QW = CLK_W + 1;

  // Register stages inside one ratio lane
  localparam int LANE_LAT = 5;

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(24000000);

  // Defaults for the top-level parameters
  localparam int RATIO_MIN_DEF   = 4;
  localparam int RATIO_MAX_DEF   = 32;
  localparam int DIVISOR_MAX_DEF = 8191;

endpackage

@@ rtl/bds_div.sv @@
module bds_div
  import bds_pkg::*;
(
  input  logic              clk,
  input  logic [CLK_W-1:0]  clk_hz,
  input  logic [BAUD_W-1:0] baud,
  output logic [QW-1:0]     quo,
  output logic [BAUD_W-1:0] baud_out
);

  // Row 0 is the stage input, row QW the registered output
  logic [QW-1:0]     num_s [QW+1];
  logic [QW-1:0]     quo_s [QW+1];
  logic [BAUD_W-1:0] rem_s [QW+1];
  logic [BAUD_W-1:0] den_s [QW+1];

  assign num_s[0] = {clk_hz, 1'b0};
  assign quo_s[0] = '0;
  assign rem_s[0] = '0;
  assign den_s[0] = baud;

  // One quotient bit per stage, most significant first
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [BAUD_W:0] trial;
    logic            ge;

    assign trial = {rem_s[i], num_s[i][QW-1-i]};
    assign ge    = trial >= {1'b0, den_s[i]};

    always_ff @(posedge clk) begin
      num_s[i+1] <= num_s[i];
      den_s[i+1] <= den_s[i];
      quo_s[i+1] <= quo_s[i] | (QW'(ge) << (QW-1-i));
      if (ge) begin
        rem_s[i+1] <= BAUD_W'(trial - {1'b0, den_s[i]});
      end else begin
        rem_s[i+1] <= BAUD_W'(trial);
      end
    end
  end

  assign quo      = quo_s[QW];
  assign baud_out = den_s[QW];

endmodule

@@ rtl/bds_lane.sv @@
module bds_lane
  import bds_pkg::*;
#(
  parameter int R    = 4,
  parameter int RW   = 6,
  parameter int DW   = 13,
  parameter int DMAX = 8191,
  parameter int EW   = DW + BAUD_W + RW
) (
  input  logic              clk,
  input  logic [QW-1:0]     q,
  input  logic [BAUD_W-1:0] baud,
  input  logic [CLK_W-1:0]  clk_hz,
  output logic [EW-1:0]     err,
  output logic [DW-1:0]     div
);

  localparam int VW  = QW + 1;
  localparam int NW  = BAUD_W + RW;
  localparam int PW  = 2 * VW;
  localparam int TW  = VW + RW + 1;
  localparam logic [VW-1:0] C = VW'(2 * R);
  localparam logic [VW-1:0] M = VW'((64'(1) << VW) / (2 * R));

  logic [VW-1:0] v0, v1, qe2, rem2, qe, qf;
  logic [NW-1:0] den0, den1, den2, den3;
  logic [PW-1:0] p1;
  logic [TW-1:0] t;
  logic [DW-1:0] d3;
  logic [EW-1:0] prod, clk_ext;

  assign qe      = p1[PW-1:VW];
  assign t       = TW'(qe) * TW'(C);
  assign qf      = qe2 + VW'(rem2 >= C);
  assign prod    = EW'(d3) * EW'(den3);
  assign clk_ext = EW'(clk_hz);

  // Round by floor((q + r) / 2r) through a reciprocal, then correct once
  always_ff @(posedge clk) begin
    v0   <= VW'(q) + VW'(R);
    den0 <= NW'(baud) * NW'(R);
    p1   <= PW'(v0) * PW'(M);
    v1   <= v0;
    den1 <= den0;
    qe2  <= qe;
    rem2 <= v1 - t[VW-1:0];
    den2 <= den1;
    den3 <= den2;
    if (qf == '0) begin
      d3 <= DW'(1);
    end else if (qf > VW'(DMAX)) begin
      d3 <= DW'(DMAX);
    end else begin
      d3 <= qf[DW-1:0];
    end
    // Error against the clock for the clamped divisor
    if (prod >= clk_ext) begin
      err <= prod - clk_ext;
    end else begin
      err <= clk_ext - prod;
    end
    div <= d3;
  end

endmodule

@@ rtl/bds_select.sv @@
module bds_select
  import bds_pkg::*;
#(
  parameter int N  = 29,
  parameter int RW = 6,
  parameter int DW = 13,
  parameter int EW = 43,
  parameter int L  = 5
) (
  input  logic          clk,
  input  logic [EW-1:0] err_in [N],
  input  logic [RW-1:0] ratio_in [N],
  input  logic [DW-1:0] div_in [N],
  output logic [RW-1:0] ratio,
  output logic [DW-1:0] div
);

  localparam int NP = 1 << L;

  logic [EW-1:0] e_l [L+1][NP];
  logic [RW-1:0] r_l [L+1][NP];
  logic [DW-1:0] d_l [L+1][NP];

  // Pad unused leaves with an error no lane can reach
  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign e_l[0][j] = err_in[j];
      assign r_l[0][j] = ratio_in[j];
      assign d_l[0][j] = div_in[j];
    end else begin : g_pad
      assign e_l[0][j] = '1;
      assign r_l[0][j] = '0;
      assign d_l[0][j] = '0;
    end
  end

  // Keep the upper entry on a tie so the larger ratio wins
  for (genvar lv = 1; lv <= L; lv++) begin : g_level
    for (genvar j = 0; j < (NP >> lv); j++) begin : g_node
      always_ff @(posedge clk) begin
        if (e_l[lv-1][2*j+1] <= e_l[lv-1][2*j]) begin
          e_l[lv][j] <= e_l[lv-1][2*j+1];
          r_l[lv][j] <= r_l[lv-1][2*j+1];
          d_l[lv][j] <= d_l[lv-1][2*j+1];
        end else begin
          e_l[lv][j] <= e_l[lv-1][2*j];
          r_l[lv][j] <= r_l[lv-1][2*j];
          d_l[lv][j] <= d_l[lv-1][2*j];
        end
      end
    end
    for (genvar j = (NP >> lv); j < NP; j++) begin : g_idle
      assign e_l[lv][j] = '1;
      assign r_l[lv][j] = '0;
      assign d_l[lv][j] = '0;
    end
  end

  assign ratio = r_l[L][0];
  assign div   = d_l[L][0];

endmodule

@@ rtl/baud_divisor_search.sv @@
// Baud divisor search.
// Start a transfer by raising start with a baud_rate; busy is always low,
// so one request is taken every clock cycle. The block tries every
// oversampling ratio from RATIO_MIN to RATIO_MAX, rounds the divisor for
// each to nearest, clamps it to 1..DIVISOR_MAX, and returns the pair with
// the smallest clock error, the larger ratio on a tie.
// Each result shows on oversample_ratio and baud_divisor for one cycle
// with done high. A request passes through the one-bit-per-stage divide
// of twice the clock by the baud rate, the five-stage per-ratio lanes
// and the registered compare tree. Throughput is one item per cycle.
// The receiver cannot hold results off, so nothing in the pipeline stalls.
// Write ref_clock_hz through cfg_we / cfg_wdata while no request is in
// flight. Reset empties the pipeline and loads a 24 MHz reference clock.
module baud_divisor_search
  import bds_pkg::*;
#(
  parameter int RATIO_MIN   = RATIO_MIN_DEF,
  parameter int RATIO_MAX   = RATIO_MAX_DEF,
  parameter int DIVISOR_MAX = DIVISOR_MAX_DEF,
  parameter int RW          = $clog2(RATIO_MAX + 1),
  parameter int DW          = $clog2(DIVISOR_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [BAUD_W-1:0] baud_rate,
  input  logic              cfg_we,
  input  logic [CLK_W-1:0]  cfg_wdata,
  output logic              done,
  output logic [RW-1:0]     oversample_ratio,
  output logic [DW-1:0]     baud_divisor
);

  localparam int N   = RATIO_MAX - RATIO_MIN + 1;
  localparam int L   = $clog2(N);
  localparam int EW  = DW + BAUD_W + RW;
  localparam int TOT = QW + LANE_LAT + L;

  logic [CLK_W-1:0]  ref_clk;
  logic [TOT-1:0]    vld;
  logic [QW-1:0]     quo;
  logic [BAUD_W-1:0] baud_d;
  logic [EW-1:0]     err_w [N];
  logic [RW-1:0]     ratio_w [N];
  logic [DW-1:0]     div_w [N];

  assign busy = 1'b0;

  // Hold the reference clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clk <= CLK_RESET;
    end else if (cfg_we) begin
      ref_clk <= cfg_wdata;
    end
  end

  // Advance the valid marks alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOT-2:0], start};
    end
  end

  bds_div u_div (
    .clk      (clk),
    .clk_hz   (ref_clk),
    .baud     (baud_rate),
    .quo      (quo),
    .baud_out (baud_d)
  );

  for (genvar k = 0; k < N; k++) begin : g_lane
    assign ratio_w[k] = RW'(RATIO_MIN + k);
    bds_lane #(
      .R    (RATIO_MIN + k),
      .RW   (RW),
      .DW   (DW),
      .DMAX (DIVISOR_MAX),
      .EW   (EW)
    ) u_lane (
      .clk    (clk),
      .q      (quo),
      .baud   (baud_d),
      .clk_hz (ref_clk),
      .err    (err_w[k]),
      .div    (div_w[k])
    );
  end

  bds_select #(
    .N  (N),
    .RW (RW),
    .DW (DW),
    .EW (EW),
    .L  (L)
  ) u_sel (
    .clk      (clk),
    .err_in   (err_w),
    .ratio_in (ratio_w),
    .div_in   (div_w),
    .ratio    (oversample_ratio),
    .div      (baud_divisor)
  );

  assign done = vld[TOT-1];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##TOT done)
    else $error("request did not complete at the pipeline depth");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (oversample_ratio >= RW'(RATIO_MIN)) && (oversample_ratio <= RW'(RATIO_MAX)))
    else $error("chosen ratio out of range");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (baud_divisor != '0) && (baud_divisor <= DW'(DIVISOR_MAX)))
    else $error("chosen divisor out of range");

endmodule

@@ dv/baud_divisor_search_tb.sv @@
module baud_divisor_search_tb;
  import bds_pkg::*;

  localparam int RMIN = RATIO_MIN_DEF;
  localparam int RMAX = RATIO_MAX_DEF;
  localparam int DMAX = DIVISOR_MAX_DEF;
  localparam int RW = $clog2(RMAX + 1);
  localparam int DW = $clog2(DMAX + 1);
  localparam int PIPE_DRAIN = 60;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [RW-1:0] ratio;
    logic [DW-1:0] divisor;
  } setting_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [BAUD_W-1:0] baud_rate;
  logic              cfg_we;
  logic [CLK_W-1:0]  cfg_wdata;
  logic              done;
  logic [RW-1:0]     oversample_ratio;
  logic [DW-1:0]     baud_divisor;

  logic [BAUD_W-1:0] pending_bauds[$];
  setting_t          expected_settings[$];
  logic [CLK_W-1:0]  clock_hz;
  int                send_idle_pct;
  int                mismatches;
  int                transfers_in;
  int                results_seen;
  int                quiet_cycles;
  int                clock_settings;

  baud_divisor_search dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .baud_rate(baud_rate),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .oversample_ratio(oversample_ratio),
    .baud_divisor(baud_divisor)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Search every ratio for the divisor with the smallest clock error
  function automatic setting_t best_setting(logic [CLK_W-1:0] ref_hz, logic [BAUD_W-1:0] baud);
    logic [63:0] den, div, prod, err, best_err;
    setting_t    pick;
    best_err = '1;
    pick = '0;
    for (int r = RMIN; r <= RMAX; r++) begin
      den = 64'(baud) * 64'(r);
      if (den == 0) div = DMAX;
      else div = (2 * 64'(ref_hz) + den) / (2 * den);
      if (div < 1) div = 1;
      else if (div > DMAX) div = DMAX;
      prod = div * 64'(r) * 64'(baud);
      err = (prod >= 64'(ref_hz)) ? prod - 64'(ref_hz) : 64'(ref_hz) - prod;
      if (err <= best_err) begin
        best_err = err;
        pick.ratio = RW'(r);
        pick.divisor = DW'(div);
      end
    end
    return pick;
  endfunction

  // Drive requests on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (pending_bauds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      start <= 1'b1;
      baud_rate <= pending_bauds[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Take transfers in, check results, watch for a hang
  always @(posedge clk) begin
    setting_t want;
    logic     moved;
    moved = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        expected_settings.push_back(best_setting(clock_hz, baud_rate));
        void'(pending_bauds.pop_front());
        transfers_in++;
        moved = 1'b1;
      end
      if (done) begin
        moved = 1'b1;
        results_seen++;
        if (expected_settings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result ratio=%0d divisor=%0d", oversample_ratio, baud_divisor);
        end else begin
          want = expected_settings.pop_front();
          if (oversample_ratio !== want.ratio || baud_divisor !== want.divisor) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected ratio=%0d divisor=%0d, got ratio=%0d divisor=%0d",
                       want.ratio, want.divisor, oversample_ratio, baud_divisor);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Hold off until the pipe is empty, then load a new reference clock
  task automatic set_clock(logic [CLK_W-1:0] hz);
    wait (pending_bauds.size() == 0 && expected_settings.size() == 0);
    repeat (PIPE_DRAIN) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    @(negedge clk);
    cfg_we <= 1'b0;
    clock_hz = hz;
    clock_settings++;
  endtask

  // Mix common rates, tiny rates, rates near an exact fit and raw noise
  task automatic queue_random(int count);
    logic [BAUD_W-1:0] b;
    int unsigned       pick;
    int unsigned       common[8] = '{300, 1200, 9600, 19200, 57600, 115200, 921600, 3000000};
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: b = BAUD_W'(common[$urandom_range(0, 7)]);
        1: b = BAUD_W'($urandom_range(0, 2000));
        2: b = BAUD_W'(clock_hz / ($urandom_range(RMIN, RMAX) * $urandom_range(1, 64))
               + $urandom_range(0, 2));
        default: b = BAUD_W'($urandom());
      endcase
      pending_bauds.push_back(b);
    end
  endtask

  initial begin
    int unsigned directed[20] = '{0, 1, 2, 3, 300, 9600, 115200, 230400, 1000000, 3000000,
                                  6000000, 8000000, 12000000, 16777215, 8388608, 5592405,
                                  11184810, 183, 732, 24};
    int idle_plan[6] = '{0, 74, 0, 28, 74, 0};
    logic [CLK_W-1:0] clock_plan[6];
    start = 1'b0;
    baud_rate = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    clock_hz = CLK_RESET;
    send_idle_pct = 0;
    mismatches = 0;
    transfers_in = 0;
    results_seen = 0;
    quiet_cycles = 0;
    clock_settings = 0;
    clock_plan = '{CLK_RESET, 28'd0, 28'hFFFFFFF, 28'd1, 28'd48000000, CLK_W'($urandom())};
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed rates at the reset clock, then at the clock extremes
    foreach (directed[i]) pending_bauds.push_back(BAUD_W'(directed[i]));
    for (int p = 1; p <= 3; p++) begin
      set_clock(clock_plan[p]);
      foreach (directed[i]) pending_bauds.push_back(BAUD_W'(directed[i]));
    end

    // Random phases, each with its own clock and send gaps
    for (int p = 0; p < 6; p++) begin
      set_clock(clock_plan[p]);
      send_idle_pct = idle_plan[p];
      queue_random(120);
    end

    wait (pending_bauds.size() == 0 && expected_settings.size() == 0);
    repeat (PIPE_DRAIN) @(negedge clk);
    $display("%0d baud requests sent, %0d results checked, %0d reference clocks",
             transfers_in, results_seen, clock_settings);
    if (mismatches == 0 && expected_settings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
